// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/itss_pkg.sv =====
// package for the irq table signature scanner: types, signatures, sizes
// and register map
// no dependencies
package itss_pkg;

    typedef logic [31:0] t_word;

    // scan phases
    typedef enum logic [2:0] {
        PH_SEEK_START,
        PH_SEEK_END,
        PH_GET_TABLE,
        PH_GET_RETURN,
        PH_FAILED,
        PH_DONE
    } t_phase;

    localparam int START_LEN = 5;
    localparam int END_LEN   = 4;

    localparam t_word START_SIG [START_LEN] = '{
        32'he92d4000, 32'he3a0c301, 32'he28cce21, 32'he51c1008, 32'he3510000
    };
    localparam t_word END_SIG [END_LEN] = '{
        32'he59f1008, 32'he7910100, 32'he59fe004, 32'he12fff10
    };

    // end signature must begin within this many words of the start
    localparam int END_WINDOW = 50;
    localparam int WIN_W      = $clog2(END_WINDOW + 1);

    // word position counter, saturating
    localparam int  REGION_WORDS = 1048576;
    localparam int  POS_W        = 20;
    localparam longint POS_MAX   = (longint'(1) << POS_W) - 1;
    localparam longint POS_LIM_L = (REGION_WORDS - 1 < POS_MAX) ?
                                   longint'(REGION_WORDS - 1) : POS_MAX;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIM_L);

    // register map: index bits above the byte lane
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_REGION_BASE = '0;

endpackage

// ===== rtl/irq_table_signature_scanner.sv =====
// irq table signature scanner top level; uses itss_pkg
// the result of a taken input word is registered and shows in the output register in the next cycle
// throughput: one code word per cycle while no stalled result holds the input side, set by the single register stage
// a stalled output holds the input side only while its result is not taken
// reset (synchronous, active low) clears phase, word position, window count, region_base and the output valid
// no clearing pass: the scanner takes words in the first cycle after reset
module irq_table_signature_scanner
    import itss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // code word stream
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_code_word,
    input  logic              i_last_word,
    // result stream
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [31:0]       o_table_address,
    output logic [POS_W-1:0]  o_start_offset
);

    // scan state
    t_phase           r_phase, n_phase;
    t_word            r_hist [4];          // [0] is the newest previous word
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_start_pos;
    logic [WIN_W-1:0] r_wcnt, n_wcnt;
    t_word            r_tp;                // table pointer pre-offset by 4*(r+1)
    t_word            r_base;

    // output register
    logic             r_o_valid;
    logic             r_found;
    t_word            r_addr;
    logic [POS_W-1:0] r_off;

    logic  w_acc;
    logic  w_start_hit;
    logic  w_end_hit;
    logic  w_end_ok;
    logic  w_win_out;
    logic  w_emit_found;
    logic  w_emit_miss;
    logic  w_cfg_wr;
    t_word w_ret_addr;
    t_word w_tp_next;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[ADDR_W-1:2] == REG_REGION_BASE);
    assign prdata   = (paddr[ADDR_W-1:2] == REG_REGION_BASE) ? r_base : '0;

    // ---------------------------------------------------------------
    // handshake: the output register parts the two sides, so a new
    // word is taken whenever the pending result leaves this cycle
    // ---------------------------------------------------------------
    assign o_ready = !r_o_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    // ---------------------------------------------------------------
    // signature compares and arithmetic
    // ---------------------------------------------------------------
    // start signature needs five words of this region, the newest is the input
    assign w_start_hit = (r_pos >= POS_W'(START_LEN - 1)) &&
                         (r_hist[3] == START_SIG[0]) &&
                         (r_hist[2] == START_SIG[1]) &&
                         (r_hist[1] == START_SIG[2]) &&
                         (r_hist[0] == START_SIG[3]) &&
                         (i_code_word == START_SIG[4]);

    assign w_end_hit = (r_hist[2] == END_SIG[0]) &&
                       (r_hist[1] == END_SIG[1]) &&
                       (r_hist[0] == END_SIG[2]) &&
                       (i_code_word == END_SIG[3]);

    // saturating word position
    assign n_pos  = (r_pos < POS_LIMIT) ? r_pos + 1'b1 : r_pos;
    // window count stays below its maximum: the phase leaves before it wraps
    assign n_wcnt = r_wcnt + 1'b1;

    assign w_end_ok  = (int'(n_wcnt) + 2) <= END_WINDOW;
    assign w_win_out = (int'(n_wcnt) + 2) >= END_WINDOW;

    // the return word sits at index n_pos, so 4*(r+1) is folded into the
    // stored table pointer; a multiple of four passes through the mask
    assign w_tp_next  = i_code_word +
                        32'({(POS_W + 1)'(n_pos) + 1'b1, 2'b00});
    assign w_ret_addr = r_base + ((r_tp - i_code_word) & ~32'h3);

    // ---------------------------------------------------------------
    // phase sequencing
    // ---------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            if (i_last_word) begin
                // region end: phase and word position return to their reset values
                n_phase = PH_SEEK_START;
            end else begin
                unique case (r_phase)
                    PH_SEEK_START: begin
                        if (w_start_hit) n_phase = PH_SEEK_END;
                    end
                    PH_SEEK_END: begin
                        if (w_end_hit && w_end_ok) begin
                            n_phase = PH_GET_TABLE;
                        end else if (w_win_out) begin
                            n_phase = PH_FAILED;
                        end
                    end
                    PH_GET_TABLE:  n_phase = PH_GET_RETURN;
                    PH_GET_RETURN: n_phase = PH_DONE;
                    PH_FAILED:     n_phase = PH_FAILED;
                    PH_DONE:       n_phase = PH_DONE;
                    default:       n_phase = PH_SEEK_START;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // result decode: a hit on the return word, or a miss on the last
    // word; after a hit the rest of the region gives nothing
    // ---------------------------------------------------------------
    always_comb begin
        w_emit_found = w_acc && (r_phase == PH_GET_RETURN);
        w_emit_miss  = w_acc && i_last_word &&
                       (r_phase != PH_GET_RETURN) && (r_phase != PH_DONE);
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEEK_START;
            r_pos     <= '0;
            r_wcnt    <= '0;
            r_base    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;

            if (w_cfg_wr) begin
                r_base <= pwdata;
            end

            if (w_acc) begin
                if (i_last_word) begin
                    r_pos <= '0;
                end else if (r_phase != PH_DONE) begin
                    r_pos <= n_pos;
                end
                if (r_phase == PH_SEEK_START && w_start_hit) begin
                    r_wcnt <= '0;
                end else if (r_phase == PH_SEEK_END) begin
                    r_wcnt <= n_wcnt;
                end
            end

            if (w_emit_found || w_emit_miss) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_acc && r_phase != PH_DONE) begin
            r_hist[3] <= r_hist[2];
            r_hist[2] <= r_hist[1];
            r_hist[1] <= r_hist[0];
            r_hist[0] <= i_code_word;
        end
        if (w_acc && r_phase == PH_SEEK_START && w_start_hit) begin
            r_start_pos <= r_pos - POS_W'(START_LEN - 1);
        end
        if (w_acc && r_phase == PH_GET_TABLE) begin
            r_tp <= w_tp_next;
        end
        if (w_emit_found) begin
            r_found <= 1'b1;
            r_addr  <= w_ret_addr;
            r_off   <= r_start_pos;
        end else if (w_emit_miss) begin
            r_found <= 1'b0;
            r_addr  <= '0;
            r_off   <= '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_found         = r_found;
    assign o_table_address = r_addr;
    assign o_start_offset  = r_off;

endmodule

// ===== rtl/itss_checker.sv =====
// port-level checker for the irq table signature scanner, bound to the top level
// depends on assert_macros.svh and itss_pkg
`include "assert_macros.svh"
module itss_checker
    import itss_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_found,
    input logic [31:0]      o_table_address,
    input logic [POS_W-1:0] o_start_offset
);

    // a miss carries zero address and offset
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found |-> o_table_address == 0 && o_start_offset == 0, "miss result with nonzero payload")

    // a stalled result blocks the input side
    `ASSERT_CLK(a_stall_blocks_in, i_clk, i_rst_n, o_valid && !i_ready |-> !o_ready, "input taken while result stalled")

    // a stalled result is held unchanged
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_table_address) && $stable(o_start_offset), "stalled result changed")

    // reset empties the output register
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind irq_table_signature_scanner itss_checker u_itss_checker (.*);
